@@ design/bblur_pkg.sv @@
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and a helper function of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int WIN       = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_RESET = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int CELL_RIGHT  = 0;
  localparam int CELL_CENTER = 1;
  localparam int CELL_LEFT   = 2;

  localparam int COL_SUM_W   = 10;
  localparam int WIN_SUM_W   = 12;
  localparam int NUM_W       = 13;
  localparam int MUL_IN_W    = 12;
  localparam int RECIP_W     = 15;
  localparam int PROD_W      = 27;
  localparam int CNT_W       = 4;
  localparam int DIV_SHIFT_W = 2;
  localparam int RECIP_SHIFT = 14;

  localparam logic [RECIP_W-1:0] RECIP_ONE   = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 15'd5462;
  localparam logic [RECIP_W-1:0] RECIP_NINTH = 15'd1821;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef logic [NUM_CH-1:0][COL_SUM_W-1:0] col_sum_t;
  typedef logic [WIN-1:0][NUM_CH-1:0][COL_SUM_W-1:0] win_sums_t;

  typedef struct packed {
    logic top;
    logic bot;
  } row_mask_t;

  typedef struct packed {
    row_mask_t rows;
    logic      left;
    logic      right;
  } win_mask_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctrl_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } avg_ctrl_t;

  typedef struct packed {
    logic [DIV_SHIFT_W-1:0] shift;
    logic [RECIP_W-1:0]     recip;
  } div_param_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  // Rounded mean is (2*sum + count) / (2*count): a shift by the power of two
  // in 2*count, then a multiply by the reciprocal of the odd factor.
  function automatic div_param_t div_params(input logic [CNT_W-1:0] count);
    div_param_t p;
    unique case (count)
      4'd1: begin
        p.shift = 2'd1;
        p.recip = RECIP_ONE;
      end
      4'd2: begin
        p.shift = 2'd2;
        p.recip = RECIP_ONE;
      end
      4'd3: begin
        p.shift = 2'd1;
        p.recip = RECIP_THIRD;
      end
      4'd4: begin
        p.shift = 2'd3;
        p.recip = RECIP_ONE;
      end
      4'd6: begin
        p.shift = 2'd2;
        p.recip = RECIP_THIRD;
      end
      4'd9: begin
        p.shift = 2'd1;
        p.recip = RECIP_NINTH;
      end
      default: begin
        p.shift = 2'd1;
        p.recip = RECIP_ONE;
      end
    endcase
    return p;
  endfunction

endpackage

@@ design/box_blur_3x3_rgb.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB raster. Pixels enter in raster order and
// each output is the rounded mean of the in-frame pixels around one frame
// pixel, per channel, so edge and corner pixels divide by 6 or 4. The output
// for a pixel leaves with the input item that comes frame_width+1 items later,
// and frame_width+1 drain items after the frame flush the last outputs; the
// last output of a frame carries last_of_frame. A write to frame_width or
// frame_height restarts the stream at the first pixel; the user must make it
// while the block is idle, which the block itself does not enforce. Each item
// walks through a five-step sequencer: accept with the line memory read,
// window shift with the line memory write, column summing, reciprocal
// multiply and output load. An item that yields no result skips the multiply
// and output load, and a held output keeps the sequencer in output load. The
// next input is accepted while a result is still waiting on the output. The
// two line memories are MAX_WIDTH deep each and need no clearing after reset.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bblur_pkg::CH_W-1:0]           red_in,
  input  logic [bblur_pkg::CH_W-1:0]           green_in,
  input  logic [bblur_pkg::CH_W-1:0]           blue_in,
  input  logic                                 drain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bblur_pkg::CH_W-1:0]           red_out,
  output logic [bblur_pkg::CH_W-1:0]           green_out,
  output logic [bblur_pkg::CH_W-1:0]           blue_out,
  output logic                                 last_of_frame,
  input  logic                                 cfg_wr_en,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bblur_pkg::CFG_W-1:0]          cfg_data
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RESET_WIDTH  = (CFG_RESET > MAX_WIDTH)  ? MAX_WIDTH  : CFG_RESET;
  localparam int RESET_HEIGHT = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

  function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return 32'd1;
    end
    if (v32 > 32'(maxv)) begin
      return 32'(maxv);
    end
    return v32;
  endfunction

  logic [WW-1:0] frame_width;
  logic [HW-1:0] frame_height;
  logic [RW-1:0] stream_row;
  logic [CW-1:0] stream_col;
  logic [RW-1:0] stream_row_next;
  logic [CW-1:0] stream_col_next;
  logic [RW-1:0] item_row;
  logic [CW-1:0] item_col;
  pixel_t        item_pix;
  state_t        state;
  state_t        state_next;

  logic      in_accept;
  logic      cfg_hit;
  logic      produce;
  logic      item_last;
  logic      load_out;
  logic      shift;
  lb_ctrl_t  lb_ctrl;
  avg_ctrl_t avg_ctrl;
  logic [RW-1:0] center_row;
  logic [CW-1:0] center_col;
  win_mask_t     mask;
  pixel_t        lb_up1;
  pixel_t        lb_up2;
  column_t       new_col;
  column_t       cell_out [WIN];
  win_sums_t     sums;
  pixel_t        avg_result;

  assign in_accept = in_valid && !in_stall;
  assign cfg_hit   = cfg_wr_en &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WW'(RESET_WIDTH);
      frame_height <= HW'(RESET_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= WW'(clamp_dim(cfg_data, MAX_WIDTH));
        REG_FRAME_HEIGHT: frame_height <= HW'(clamp_dim(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // The stream runs through the frame, one extra row of drain positions and one more drain position.
  always_comb begin
    stream_row_next = stream_row;
    stream_col_next = stream_col + CW'(1);
    if (stream_row == RW'(frame_height) + RW'(1)) begin
      stream_row_next = '0;
      stream_col_next = '0;
    end else if (WW'(stream_col) + WW'(1) == frame_width) begin
      stream_row_next = stream_row + RW'(1);
      stream_col_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_row <= '0;
      stream_col <= '0;
    end else if (cfg_hit) begin
      stream_row <= '0;
      stream_col <= '0;
    end else if (in_accept) begin
      stream_row <= stream_row_next;
      stream_col <= stream_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_row <= stream_row;
      item_col <= stream_col;
      item_pix <= drain ? pixel_t'(0) : {blue_in, green_in, red_in};
    end
  end

  always_comb begin
    produce   = (item_row >= RW'(2)) || (item_row == RW'(1) && item_col != '0);
    item_last = item_row == RW'(frame_height) + RW'(1);
    if (item_col != '0) begin
      center_row = item_row - RW'(1);
      center_col = item_col - CW'(1);
    end else begin
      center_row = item_row - RW'(2);
      center_col = CW'(frame_width - WW'(1));
    end
    mask.rows.top = center_row != '0;
    mask.rows.bot = (center_row + RW'(1)) < RW'(frame_height);
    mask.left     = center_col != '0;
    mask.right    = (WW'(center_col) + WW'(1)) < frame_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SHIFT;
      S_SHIFT: state_next = S_SUM;
      S_SUM:   state_next = produce ? S_DIV : S_IDLE;
      S_DIV:   state_next = S_OUT;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    lb_ctrl.rd_en   = 1'b0;
    lb_ctrl.wr_en   = 1'b0;
    shift           = 1'b0;
    avg_ctrl.sum_en = 1'b0;
    avg_ctrl.mul_en = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall      = 1'b0;
        lb_ctrl.rd_en = in_valid;
      end
      S_SHIFT: begin
        lb_ctrl.wr_en = 1'b1;
        shift         = 1'b1;
      end
      S_SUM:   avg_ctrl.sum_en = 1'b1;
      S_DIV:   avg_ctrl.mul_en = 1'b1;
      S_OUT:   load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  bblur_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .ctrl     (lb_ctrl),
    .rd_addr  (stream_col),
    .wr_addr  (item_col),
    .wr_pixel (item_pix),
    .up1      (lb_up1),
    .up2      (lb_up2)
  );

  assign new_col.top = lb_up2;
  assign new_col.mid = lb_up1;
  assign new_col.bot = item_pix;

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    if (i == 0) begin : g_head
      bblur_col_cell u_cell (
        .clk     (clk),
        .shift   (shift),
        .col_in  (new_col),
        .rows    (mask.rows),
        .col_out (cell_out[i]),
        .col_sum (sums[i])
      );
    end else begin : g_link
      bblur_col_cell u_cell (
        .clk     (clk),
        .shift   (shift),
        .col_in  (cell_out[i-1]),
        .rows    (mask.rows),
        .col_out (cell_out[i]),
        .col_sum (sums[i])
      );
    end
  end

  bblur_average u_average (
    .clk    (clk),
    .ctrl   (avg_ctrl),
    .sums   (sums),
    .mask   (mask),
    .result (avg_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_out       <= avg_result[CH_RED];
      green_out     <= avg_result[CH_GREEN];
      blue_out      <= avg_result[CH_BLUE];
      last_of_frame <= item_last;
    end
  end

endmodule

@@ design/bblur_line_buf.sv @@
// ----------------------------------------------------------------------------
// bblur_line_buf
// Two line memories holding the previous two rows, indexed by column.
// ----------------------------------------------------------------------------
module bblur_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  bblur_pkg::lb_ctrl_t      ctrl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bblur_pkg::pixel_t        wr_pixel,
  output bblur_pkg::pixel_t        up1,
  output bblur_pkg::pixel_t        up2
);
  import bblur_pkg::*;

  pixel_t mem0 [DEPTH];
  pixel_t mem1 [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      up1 <= mem0[rd_addr];
      up2 <= mem1[rd_addr];
    end
  end

  // The row above moves down one line as the new pixel takes its place.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem0[wr_addr] <= wr_pixel;
      mem1[wr_addr] <= up1;
    end
  end

endmodule

@@ design/bblur_col_cell.sv @@
// ----------------------------------------------------------------------------
// bblur_col_cell
// One column of the 3x3 window; passes its column on and sums its rows.
// ----------------------------------------------------------------------------
module bblur_col_cell (
  input  logic                 clk,
  input  logic                 shift,
  input  bblur_pkg::column_t   col_in,
  input  bblur_pkg::row_mask_t rows,
  output bblur_pkg::column_t   col_out,
  output bblur_pkg::col_sum_t  col_sum
);
  import bblur_pkg::*;

  column_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      col_sum[ch] = COL_SUM_W'(col.mid[ch])
                  + (rows.top ? COL_SUM_W'(col.top[ch]) : COL_SUM_W'(0))
                  + (rows.bot ? COL_SUM_W'(col.bot[ch]) : COL_SUM_W'(0));
    end
  end

endmodule

@@ design/bblur_average.sv @@
// ----------------------------------------------------------------------------
// bblur_average
// Adds the window columns and forms the rounded mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module bblur_average (
  input  logic                 clk,
  input  bblur_pkg::avg_ctrl_t ctrl,
  input  bblur_pkg::win_sums_t sums,
  input  bblur_pkg::win_mask_t mask,
  output bblur_pkg::pixel_t    result
);
  import bblur_pkg::*;

  logic [1:0]           n_rows;
  logic [1:0]           n_cols;
  logic [CNT_W-1:0]     count;
  div_param_t           param_now;
  div_param_t           param;
  logic [WIN_SUM_W-1:0] win_sum [NUM_CH];
  logic [NUM_W-1:0]     num_now [NUM_CH];
  logic [NUM_W-1:0]     num     [NUM_CH];
  logic [MUL_IN_W-1:0]  mul_in  [NUM_CH];
  logic [PROD_W-1:0]    prod    [NUM_CH];

  always_comb begin
    n_rows    = 2'd1 + 2'(mask.rows.top) + 2'(mask.rows.bot);
    n_cols    = 2'd1 + 2'(mask.left) + 2'(mask.right);
    count     = CNT_W'(n_rows) * CNT_W'(n_cols);
    param_now = div_params(count);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_sum[ch] = WIN_SUM_W'(sums[CELL_CENTER][ch])
                  + (mask.left  ? WIN_SUM_W'(sums[CELL_LEFT][ch])  : WIN_SUM_W'(0))
                  + (mask.right ? WIN_SUM_W'(sums[CELL_RIGHT][ch]) : WIN_SUM_W'(0));
      num_now[ch] = NUM_W'({win_sum[ch], 1'b0}) + NUM_W'(count);
      mul_in[ch]  = MUL_IN_W'(num[ch] >> param.shift);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      num   <= num_now;
      param <= param_now;
    end
    if (ctrl.mul_en) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod[ch] <= PROD_W'(mul_in[ch]) * PROD_W'(param.recip);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      result[ch] = prod[ch][RECIP_SHIFT +: CH_W];
    end
  end

endmodule
